// ===== hdl/pli_pkg.sv =====
// ---------------------------------------------------------------------------
// pli_pkg
// Shared constants for the path linear interpolator.
// ---------------------------------------------------------------------------
package pli_pkg;

    localparam int MAX_POINTS_DEF = 256;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] OM_LOOP    = 2'd0;
    localparam logic [1:0] OM_CLAMP   = 2'd1;
    localparam logic [1:0] OM_REVERSE = 2'd2;

    localparam logic [1:0] REG_CLOSED = 2'd0;
    localparam logic [1:0] REG_OUTSIDE = 2'd1;
    localparam logic [1:0] REG_MOTION = 2'd2;

    localparam logic KIND_ADD = 1'b0;

endpackage

// ===== hdl/path_linear_interpolator.sv =====
// ---------------------------------------------------------------------------
// path_linear_interpolator
// Point table in RAM with linear blending between neighboring points.
// ---------------------------------------------------------------------------
// One item at a time. An add item, or an interpolation on fewer than two
// points, gives its result the cycle after it is accepted, and the next item
// is taken the cycle after that result leaves. An interpolate item runs the
// floored modulo of the integer index by the segment count (or twice it) in
// a restoring divider, whose dividend width is 28 bits for 256 points: one
// quotient bit per cycle plus a setup and a fix-up step, once for each of
// the two indices; then two RAM reads and two blend multiplies per
// coordinate. Clamp mode needs no divider. Status 1 marks fewer than two
// points, status 2 a dropped add on a full table.
module path_linear_interpolator #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // point_x, point_y, progress
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // out_x, out_y, status, zero fill
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    // index range: 2N fits in CW+1 bits, signed integer part of t is 17+NW bits
    localparam int NW = CW + 1;
    localparam int IW = 17 + NW;
    localparam int DW = IW + 1;   // dividend width, magnitude of the signed index
    localparam int BW = $clog2(DW + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SCALE, S_PREP, S_DIV, S_DIVDONE, S_MAP,
        S_RD0, S_RD1, S_RD2, S_BL1, S_BL2, S_OUT
    } state_t;

    state_t state_reg;
    logic closed_reg, motion_reg;
    logic [1:0] outside_reg;
    logic [CW-1:0] count_reg;

    logic signed [31:0] prog_reg;
    logic signed [63:0] prod_reg;
    logic signed [IW+15:0] t_reg;
    logic [NW-1:0] n_reg, m_reg;
    logic [DW-1:0] rem_reg, quo_reg;
    logic [BW-1:0] bit_reg;
    logic which_reg;
    logic neg_reg;
    logic [NW-1:0] mi_reg, mj_reg;
    logic [AW-1:0] ai_reg, aj_reg;
    logic signed [31:0] xi_reg, yi_reg;
    logic signed [48:0] ax_reg, ay_reg;
    logic [31:0] ox_reg, oy_reg;
    logic [1:0] st_reg;
    logic valid_reg;

    logic [AW-1:0] raddr;
    logic [31:0] xr, yr;
    logic we;

    assign we = (state_reg == S_IDLE) && s_tvalid && !valid_reg && s_tuser == pli_pkg::KIND_ADD
        && ({1'b0, count_reg} < (CW+1)'(MAX_POINTS));

    pli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_x (
        .clk(clk), .we(we), .waddr(count_reg[AW-1:0]), .wdata(s_tdata[31:0]),
        .raddr(raddr), .rdata(xr));
    pli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_y (
        .clk(clk), .we(we), .waddr(count_reg[AW-1:0]), .wdata(s_tdata[63:32]),
        .raddr(raddr), .rdata(yr));

    assign raddr = (state_reg == S_RD0) ? ai_reg : aj_reg;
    assign s_tready = (state_reg == S_IDLE) && !valid_reg;
    assign m_tvalid = valid_reg;
    assign m_tdata = {6'd0, st_reg, oy_reg, ox_reg};

    // integer part and fraction of t
    logic signed [IW-1:0] lo;
    logic [15:0] frac;
    logic signed [IW-1:0] hi;
    assign lo = t_reg[IW+15:16];
    assign frac = t_reg[15:0];
    assign hi = lo + IW'(frac != 16'd0);

    // divide the magnitude, the sign is folded back into the remainder afterwards
    logic signed [IW-1:0] dsel;
    assign dsel = which_reg ? hi : lo;

    logic [DW:0] trial;
    assign trial = {rem_reg, quo_reg[DW-1]} - {(DW+1-NW)'(0), m_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            closed_reg <= 1'b0;
            outside_reg <= pli_pkg::OM_LOOP;
            motion_reg <= 1'b0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pli_pkg::REG_CLOSED:  closed_reg <= cfg_data[0];
                    pli_pkg::REG_OUTSIDE: outside_reg <= cfg_data;
                    pli_pkg::REG_MOTION:  motion_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (valid_reg && m_tready)
            begin
                valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && !valid_reg)
                    begin
                        prog_reg <= s_tdata[95:64];
                        ox_reg <= '0;
                        oy_reg <= '0;
                        if (s_tuser == pli_pkg::KIND_ADD)
                        begin
                            valid_reg <= 1'b1;
                            if (we)
                            begin
                                count_reg <= count_reg + 1'b1;
                                st_reg <= pli_pkg::ST_OK;
                            end
                            else
                            begin
                                st_reg <= pli_pkg::ST_FULL;
                            end
                        end
                        else if (count_reg < CW'(2))
                        begin
                            st_reg <= pli_pkg::ST_FEW;
                            valid_reg <= 1'b1;
                        end
                        else
                        begin
                            n_reg <= closed_reg ? NW'(count_reg) : NW'(count_reg) - 1'b1;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg <= 64'(prog_reg) * $signed({1'b0, n_reg});
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    logic signed [63:0] tv;
                    tv = motion_reg ? 64'(prog_reg) : prod_reg;
                    if (!motion_reg && prod_reg > 64'sd2147483647)
                        tv = 64'sd2147483647;
                    else if (!motion_reg && prod_reg < -64'sd2147483648)
                        tv = -64'sd2147483648;
                    if (outside_reg == pli_pkg::OM_REVERSE && tv < 0)
                        tv = ($signed({1'b0, n_reg, 17'd0})) - tv;
                    t_reg <= (IW+16)'(tv);
                    m_reg <= (outside_reg == pli_pkg::OM_REVERSE) ? {n_reg[NW-2:0], 1'b0} : n_reg;
                    which_reg <= 1'b0;
                    state_reg <= (outside_reg == pli_pkg::OM_CLAMP) ? S_MAP : S_PREP;
                end
                S_PREP:
                begin
                    neg_reg <= dsel[IW-1];
                    quo_reg <= dsel[IW-1] ? DW'(-$signed({dsel[IW-1], dsel})) : DW'(dsel);
                    rem_reg <= '0;
                    bit_reg <= BW'(DW);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (!trial[DW])
                    begin
                        rem_reg <= trial[DW-1:0];
                        quo_reg <= {quo_reg[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[DW-2:0], quo_reg[DW-1]};
                        quo_reg <= {quo_reg[DW-2:0], 1'b0};
                    end
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == BW'(1))
                        state_reg <= S_DIVDONE;
                end
                S_DIVDONE:
                begin
                    logic [NW-1:0] r;
                    r = rem_reg[NW-1:0];
                    if (neg_reg && r != '0)
                        r = m_reg - r;
                    if (!which_reg)
                    begin
                        mi_reg <= r;
                        which_reg <= 1'b1;
                        state_reg <= S_PREP;
                    end
                    else
                    begin
                        mj_reg <= r;
                        state_reg <= S_MAP;
                    end
                end
                S_MAP:
                begin
                    logic [NW-1:0] ci, cj, cnt;
                    cnt = NW'(count_reg);
                    ci = mi_reg;
                    cj = mj_reg;
                    if (outside_reg == pli_pkg::OM_CLAMP)
                    begin
                        ci = lo < 0 ? '0 : (lo >= $signed({1'b0, n_reg}) ? n_reg : NW'(lo));
                        cj = hi < 0 ? '0 : (hi >= $signed({1'b0, n_reg}) ? n_reg : NW'(hi));
                        if (ci >= cnt) ci = '0;
                        if (cj >= cnt) cj = '0;
                    end
                    else if (outside_reg == pli_pkg::OM_REVERSE)
                    begin
                        // 2N-k lies in 1..N here, one subtract of cnt is enough
                        if (ci >= cnt)
                        begin
                            ci = m_reg - ci;
                            if (ci >= cnt) ci = ci - cnt;
                        end
                        if (cj >= cnt)
                        begin
                            cj = m_reg - cj;
                            if (cj >= cnt) cj = cj - cnt;
                        end
                    end
                    ai_reg <= AW'(ci);
                    aj_reg <= AW'(cj);
                    state_reg <= S_RD0;
                end
                S_RD0: state_reg <= S_RD1;
                S_RD1:
                begin
                    xi_reg <= xr;
                    yi_reg <= yr;
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    ax_reg <= xi_reg * $signed({1'b0, 17'(17'h10000 - {1'b0, frac})});
                    ay_reg <= yi_reg * $signed({1'b0, 17'(17'h10000 - {1'b0, frac})});
                    state_reg <= S_BL1;
                end
                S_BL1:
                begin
                    ax_reg <= ax_reg + $signed(xr) * $signed({1'b0, frac}) + 49'sd32768;
                    ay_reg <= ay_reg + $signed(yr) * $signed({1'b0, frac}) + 49'sd32768;
                    state_reg <= S_BL2;
                end
                S_BL2:
                begin
                    ox_reg <= ax_reg[47:16];
                    oy_reg <= ay_reg[47:16];
                    st_reg <= pli_pkg::ST_OK;
                    valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/pli_ram.sv =====
// ---------------------------------------------------------------------------
// pli_ram
// Generic single-port-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
